[rtl/core/msxh_pkg.sv]
// ----------------------------------------------------------------------------
// msxh_pkg
// Shared types and constants for the multi-string sum/XOR hash core.
// ----------------------------------------------------------------------------
package msxh_pkg;

  // Key shape
  localparam int MAX_PARTS  = 4;
  localparam int CHAR_W     = 8;
  localparam int PART_W     = 2;
  localparam int COUNT_W    = 3;

  // Hash word and table size
  localparam int HASH_W     = 32;
  localparam int SIZE_W     = 31;
  localparam int STEP_CNT_W = 5;   // width of the divider step counter, log2(HASH_W)

  // Sum multiplier 1 + 2^3 + 2^5 + 2^19, applied as shifted adds
  localparam int MULT_SH_A  = 3;
  localparam int MULT_SH_B  = 5;
  localparam int MULT_SH_C  = 19;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_DIV,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic acc_en;      // fold the accepted character into the accumulators
    logic hash_load;   // form the hash word, load the divider, clear accumulators
    logic div_step;    // one restoring division step
    logic out_load;    // move the remainder into the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_last;    // current step is the final division step
  } dp_sts_t;

endpackage

[rtl/core/msxh_dp.sv]
// ----------------------------------------------------------------------------
// msxh_dp
// Datapath: character accumulators, hash word formation, bit-serial
// remainder unit and the result register.
// ----------------------------------------------------------------------------
module msxh_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  msxh_pkg::dp_cmd_t                   cmd,
  output msxh_pkg::dp_sts_t                   sts,
  input  logic signed [msxh_pkg::CHAR_W-1:0]  in_char_byte,
  input  logic [msxh_pkg::PART_W-1:0]         in_part,
  input  logic [msxh_pkg::COUNT_W-1:0]        in_part_count,
  input  logic                                cfg_wr_en,
  input  logic [msxh_pkg::SIZE_W-1:0]         cfg_wr_data,
  output logic [msxh_pkg::SIZE_W-1:0]         out_index
);

  logic [msxh_pkg::HASH_W-1:0]     sum_r, sum_nxt;
  logic [msxh_pkg::CHAR_W-1:0]     xor_r   [msxh_pkg::MAX_PARTS];
  logic [msxh_pkg::CHAR_W-1:0]     xor_nxt [msxh_pkg::MAX_PARTS];
  logic [msxh_pkg::COUNT_W-1:0]    count_r;
  logic [msxh_pkg::COUNT_W-1:0]    count_clamp;
  logic [msxh_pkg::SIZE_W-1:0]     size_r;
  logic [msxh_pkg::SIZE_W-1:0]     ts_r;
  logic [msxh_pkg::HASH_W-1:0]     hword;
  logic [msxh_pkg::HASH_W-1:0]     wsum;
  logic [msxh_pkg::HASH_W-1:0]     wabs;
  logic [msxh_pkg::HASH_W-1:0]     dvd_r;
  logic [msxh_pkg::SIZE_W-1:0]     rem_r, rem_nxt;
  logic [msxh_pkg::HASH_W-1:0]     rem_sh;
  logic [msxh_pkg::HASH_W-1:0]     rem_sub;
  logic [msxh_pkg::STEP_CNT_W-1:0] step_r;
  logic [msxh_pkg::SIZE_W-1:0]     index_r;

  // Table size register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= msxh_pkg::SIZE_W'(1);
    end else if (cfg_wr_en) begin
      size_r <= cfg_wr_data;
    end
  end

  // Fold one character into the sum and its part's XOR
  always_comb begin
    sum_nxt = sum_r;
    for (int p = 0; p < msxh_pkg::MAX_PARTS; p++) begin
      xor_nxt[p] = xor_r[p];
    end
    if (32'(in_part) < msxh_pkg::MAX_PARTS) begin
      sum_nxt = sum_r + msxh_pkg::HASH_W'(in_char_byte);
      xor_nxt[in_part] = xor_r[in_part] ^ in_char_byte;
    end
  end

  // Hold accumulators; clear them once the hash word is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int p = 0; p < msxh_pkg::MAX_PARTS; p++) begin
        xor_r[p] <= '0;
      end
    end else if (cmd.hash_load) begin
      sum_r <= '0;
      for (int p = 0; p < msxh_pkg::MAX_PARTS; p++) begin
        xor_r[p] <= '0;
      end
    end else if (cmd.acc_en) begin
      sum_r <= sum_nxt;
      for (int p = 0; p < msxh_pkg::MAX_PARTS; p++) begin
        xor_r[p] <= xor_nxt[p];
      end
    end
  end

  // Keep the part count of the most recent character
  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      count_r <= in_part_count;
    end
  end

  // Clamp part count into 1..MAX_PARTS
  always_comb begin
    if (count_r == '0) begin
      count_clamp = msxh_pkg::COUNT_W'(1);
    end else if (32'(count_r) > msxh_pkg::MAX_PARTS) begin
      count_clamp = msxh_pkg::COUNT_W'(msxh_pkg::MAX_PARTS);
    end else begin
      count_clamp = count_r;
    end
  end

  // Place XOR bytes: a single part lands in the second-lowest byte
  always_comb begin
    hword = '0;
    if (count_clamp == msxh_pkg::COUNT_W'(1)) begin
      hword = msxh_pkg::HASH_W'(xor_r[0]) << msxh_pkg::CHAR_W;
    end else begin
      for (int p = 0; p < msxh_pkg::MAX_PARTS; p++) begin
        if (p < 32'(count_clamp)) begin
          hword = hword | (msxh_pkg::HASH_W'(xor_r[p]) << (msxh_pkg::CHAR_W * p));
        end
      end
    end
  end

  // Hash word with wrapping constant multiply, then its magnitude
  assign wsum = hword + sum_r + (sum_r << msxh_pkg::MULT_SH_A)
              + (sum_r << msxh_pkg::MULT_SH_B) + (sum_r << msxh_pkg::MULT_SH_C);
  assign wabs = wsum[msxh_pkg::HASH_W-1] ? (~wsum + msxh_pkg::HASH_W'(1)) : wsum;

  // Restoring remainder step
  assign rem_sh  = {rem_r, dvd_r[msxh_pkg::HASH_W-1]};
  assign rem_sub = rem_sh - msxh_pkg::HASH_W'(ts_r);
  assign rem_nxt = (rem_sh >= msxh_pkg::HASH_W'(ts_r)) ? rem_sub[msxh_pkg::SIZE_W-1:0]
                                                       : rem_sh[msxh_pkg::SIZE_W-1:0];

  // Load the divider, then advance one bit per step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.hash_load) begin
      dvd_r  <= wabs;
      rem_r  <= '0;
      ts_r   <= (size_r == '0) ? msxh_pkg::SIZE_W'(1) : size_r;
      step_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r  <= dvd_r << 1;
      rem_r  <= rem_nxt;
      step_r <= step_r + msxh_pkg::STEP_CNT_W'(1);
    end
  end

  assign sts.div_last = (step_r == '1);

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      index_r <= rem_r;
    end
  end

  assign out_index = index_r;

endmodule

[rtl/core/msxh_ctrl.sv]
// ----------------------------------------------------------------------------
// msxh_ctrl
// Controller: sequences character intake, hash formation, the remainder
// steps and the result handoff.
// ----------------------------------------------------------------------------
module msxh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output msxh_pkg::dp_cmd_t cmd,
  input  msxh_pkg::dp_sts_t sts
);

  msxh_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      msxh_pkg::ST_IDLE: begin
        if (in_valid && in_last) begin
          state_nxt = msxh_pkg::ST_HASH;
        end
      end
      msxh_pkg::ST_HASH: begin
        state_nxt = msxh_pkg::ST_DIV;
      end
      msxh_pkg::ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = msxh_pkg::ST_DONE;
        end
      end
      msxh_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = msxh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = msxh_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_stall      = 1'b1;
    cmd           = '0;
    case (state_r)
      msxh_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.acc_en = in_valid;
      end
      msxh_pkg::ST_HASH: begin
        cmd.hash_load = 1'b1;
      end
      msxh_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      msxh_pkg::ST_DONE: begin
        cmd.out_load = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Result valid: set on load, drop once taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msxh_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A last character always starts hash formation
  a_last_to_hash: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) |=> (state_r == msxh_pkg::ST_HASH))
    else $error("last transaction did not start hash formation");

  // Divider is always loaded right after hash formation
  a_hash_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msxh_pkg::ST_HASH) |=> (state_r == msxh_pkg::ST_DIV))
    else $error("divider not started after hash formation");

  // Final division step hands over to result delivery
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msxh_pkg::ST_DIV && sts.div_last) |=> (state_r == msxh_pkg::ST_DONE))
    else $error("division did not finish after its last step");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while stalled");

endmodule

[rtl/core/multi_string_sum_xor_hash_core.sv]
// ----------------------------------------------------------------------------
// multi_string_sum_xor_hash_core
// Hashes a key of one to four character strings into a table index.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle within a key.
// After the last character is accepted, the core forms the hash word, runs
//   32 remainder steps, then hands the index off to the output register.
// Intake pauses after each last character until that handoff; the bit-serial
//   remainder unit takes one key at a time. A result still waiting when the
//   next one is ready holds the handoff and stalls intake until it is taken.
// Reset: synchronous active-low; clears accumulators, sets table size to 1.
// ----------------------------------------------------------------------------
module multi_string_sum_xor_hash_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [msxh_pkg::CHAR_W-1:0]  in_char_byte,
  input  logic [msxh_pkg::PART_W-1:0]         in_part,
  input  logic [msxh_pkg::COUNT_W-1:0]        in_part_count,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [msxh_pkg::SIZE_W-1:0]         out_index,
  input  logic                                cfg_wr_en,
  input  logic [msxh_pkg::SIZE_W-1:0]         cfg_wr_data
);

  msxh_pkg::dp_cmd_t cmd;
  msxh_pkg::dp_sts_t sts;

  // Sequence control
  msxh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Accumulate, form hash, reduce
  msxh_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_char_byte  (in_char_byte),
    .in_part       (in_part),
    .in_part_count (in_part_count),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_index     (out_index)
  );

endmodule
